// File: rtl/rank9_pkg.sv
// Shared types, codes and constants for the rank9 bit-vector rank block.
// Used by rank9_ctrl, rank9_dp and rank9_bitvector_rank_top; depends on nothing.
`default_nettype none

package rank9_pkg;

  // Command codes carried on the command port.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Fixed geometry of the structure.
  localparam int WORD_W      = 64;
  localparam int POS_W       = 16;
  localparam int RANK_W      = 16;
  localparam int BIT_IDX_W   = 6;
  localparam int WIDX_W      = POS_W - BIT_IDX_W;
  localparam int BLOCK_WORDS = 8;
  localparam int SUB_W       = 9;
  localparam int SUB_FIELDS  = 7;
  localparam int SUBS_W      = SUB_W * SUB_FIELDS;
  localparam int TOTAL_W     = 17;
  localparam int BRUN_W      = 10;
  localparam int PC_W        = 7;

  // Commands from the controller to the datapath, one bit per step.
  typedef struct packed {
    logic capture;
    logic append;
    logic read;
    logic pop;
    logic sum;
    logic clear;
  } ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic beyond;
  } dp_stat_t;

  // Popcount of a 64-bit word as a six-level adder tree.
  function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
    logic [WORD_W-1:0] v4;
    logic [WORD_W-1:0] v5;
    logic [WORD_W-1:0] v6;
    v1 = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    v2 = (v1 & 64'h3333_3333_3333_3333) + ((v1 >> 2) & 64'h3333_3333_3333_3333);
    v3 = (v2 + (v2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    v4 = v3 + (v3 >> 8);
    v5 = v4 + (v4 >> 16);
    v6 = v5 + (v5 >> 32);
    return v6[PC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/rank9_ctrl.sv
// Controller state machine for the rank9 block: sequences append, query and clear steps.
// Depends on rank9_pkg; drives rank9_dp through rank9_pkg::ctrl_t.
`default_nettype none

module rank9_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          command,
  input  rank9_pkg::dp_stat_t      dp_stat,
  output rank9_pkg::ctrl_t         ctrl,
  output logic                     busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_READ,
    S_POP,
    S_SUM
  } state_t;

  state_t state;
  state_t state_next;

  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // Next state and step commands.
  always_comb begin
    state_next   = state;
    ctrl         = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command)
            rank9_pkg::CMD_APPEND: begin
              ctrl.capture = 1'b1;
              state_next   = S_APPEND;
            end
            rank9_pkg::CMD_QUERY: begin
              ctrl.capture = 1'b1;
              state_next   = S_READ;
            end
            rank9_pkg::CMD_CLEAR: begin
              ctrl.clear = 1'b1;
            end
            default: begin
              // Unused code: the beat is dropped without a result.
            end
          endcase
        end
      end
      S_APPEND: begin
        ctrl.append = 1'b1;
        state_next  = S_IDLE;
      end
      S_READ: begin
        ctrl.read  = 1'b1;
        state_next = dp_stat.beyond ? S_IDLE : S_POP;
      end
      S_POP: begin
        ctrl.pop   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        ctrl.sum   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rank9_dp.sv
// Datapath for the rank9 block: word and count memories, append update and rank sum.
// Depends on rank9_pkg; stepped by rank9_ctrl through rank9_pkg::ctrl_t.
`default_nettype none

module rank9_dp #(
  parameter int MAX_WORDS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  rank9_pkg::ctrl_t                     ctrl,
  input  wire logic [rank9_pkg::WORD_W-1:0]    data_word,
  input  wire logic [rank9_pkg::POS_W-1:0]     bit_position,
  output rank9_pkg::dp_stat_t                  dp_stat,
  output logic                                 done,
  output logic [rank9_pkg::RANK_W-1:0]         rank_value,
  output logic [1:0]                           status
);

  localparam int AW   = $clog2(MAX_WORDS);
  localparam int LW   = $clog2(MAX_WORDS + 1);
  localparam int NBLK = (MAX_WORDS + 7) / 8;
  localparam int BW   = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int CW   = (LW > rank9_pkg::WIDX_W) ? LW : rank9_pkg::WIDX_W;
  localparam logic [LW-1:0] FULL_COUNT = LW'(MAX_WORDS);

  // Memories; contents are undefined until written.
  logic [rank9_pkg::WORD_W-1:0]  word_mem [MAX_WORDS];
  logic [rank9_pkg::TOTAL_W-1:0] base_mem [NBLK];
  logic [rank9_pkg::SUBS_W-1:0]  sub_mem  [NBLK];

  // Control state of the structure.
  logic [LW-1:0]                 words_loaded;
  logic [rank9_pkg::TOTAL_W-1:0] running_total;
  logic [rank9_pkg::BRUN_W-1:0]  block_running;
  logic [rank9_pkg::SUBS_W-1:0]  sub_cur;

  // Captured beat.
  logic [rank9_pkg::WORD_W-1:0]  word_q;
  logic [rank9_pkg::POS_W-1:0]   pos_q;
  logic                          beyond_q;

  // Query pipeline registers.
  logic [rank9_pkg::WORD_W-1:0]  word_rd;
  logic [rank9_pkg::TOTAL_W-1:0] base_rd;
  logic [rank9_pkg::SUBS_W-1:0]  sub_rd;
  logic [rank9_pkg::PC_W-1:0]    pc_q;
  logic [rank9_pkg::SUB_W-1:0]   sub_q;
  logic [rank9_pkg::TOTAL_W-1:0] base_q;

  // Append signals.
  logic                          full;
  logic [AW-1:0]                 slot;
  logic [2:0]                    slot_k;
  logic [BW-1:0]                 app_blk;
  logic [rank9_pkg::PC_W-1:0]    app_pc;
  logic [rank9_pkg::BRUN_W-1:0]  brun_next;
  logic [rank9_pkg::SUBS_W-1:0]  sub_next;
  logic [5:0]                    app_shamt;

  // Query signals.
  logic [rank9_pkg::WIDX_W-1:0]  q_widx;
  logic [AW-1:0]                 q_addr;
  logic [BW-1:0]                 q_blk;
  logic [2:0]                    q_s;
  logic [5:0]                    q_shamt;
  logic [rank9_pkg::WORD_W-1:0]  q_mask;
  logic [rank9_pkg::SUBS_W-1:0]  q_sub_shifted;
  logic                          in_beyond;

  assign dp_stat.beyond = beyond_q;

  // Bounds checks.
  assign full      = (words_loaded == FULL_COUNT);
  assign in_beyond = CW'(bit_position[rank9_pkg::POS_W-1:rank9_pkg::BIT_IDX_W]) >=
                     CW'(words_loaded);

  // Append: next slot, its block, and the updated in-block counts.
  assign slot      = words_loaded[AW-1:0];
  assign slot_k    = slot[2:0];
  assign app_blk   = BW'(slot >> 3);
  assign app_pc    = rank9_pkg::popcount64(word_q);
  assign brun_next = ((slot_k == 3'd0) ? '0 : block_running) + rank9_pkg::BRUN_W'(app_pc);
  assign app_shamt = 6'(slot_k) * 6'(rank9_pkg::SUB_W);

  always_comb begin
    sub_next = (slot_k == 3'd0) ? '0 : sub_cur;
    if (slot_k != 3'd7) begin
      sub_next = sub_next |
                 (rank9_pkg::SUBS_W'(brun_next[rank9_pkg::SUB_W-1:0]) << app_shamt);
    end
  end

  // Query: word address, block, and in-block field select.
  assign q_widx        = pos_q[rank9_pkg::POS_W-1:rank9_pkg::BIT_IDX_W];
  assign q_addr        = AW'(q_widx);
  assign q_blk         = BW'(q_addr >> 3);
  assign q_s           = q_widx[2:0];
  assign q_shamt       = 6'(q_s - 3'd1) * 6'(rank9_pkg::SUB_W);
  assign q_sub_shifted = sub_rd >> q_shamt;
  assign q_mask        = (64'd1 << pos_q[rank9_pkg::BIT_IDX_W-1:0]) - 64'd1;

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (ctrl.append && !full) begin
      word_mem[slot]   <= word_q;
      sub_mem[app_blk] <= sub_next;
      if (slot_k == 3'd0) begin
        base_mem[app_blk] <= running_total;
      end
    end
    if (ctrl.read) begin
      word_rd <= word_mem[q_addr];
      base_rd <= base_mem[q_blk];
      sub_rd  <= sub_mem[q_blk];
    end
  end

  // Structure counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      words_loaded  <= '0;
      running_total <= '0;
      block_running <= '0;
    end else if (ctrl.clear) begin
      words_loaded  <= '0;
      running_total <= '0;
      block_running <= '0;
    end else if (ctrl.append && !full) begin
      words_loaded  <= words_loaded + LW'(1);
      running_total <= running_total + rank9_pkg::TOTAL_W'(app_pc);
      block_running <= brun_next;
    end
  end

  // Payload registers: captured beat, current block counts, query stages.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      word_q   <= data_word;
      pos_q    <= bit_position;
      beyond_q <= in_beyond;
    end
    if (ctrl.append && !full) begin
      sub_cur <= sub_next;
    end
    if (ctrl.pop) begin
      pc_q   <= rank9_pkg::popcount64(word_rd & q_mask);
      sub_q  <= (q_s == 3'd0) ? '0 : q_sub_shifted[rank9_pkg::SUB_W-1:0];
      base_q <= base_rd;
    end
  end

  // Result strobe and fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.append || (ctrl.read && beyond_q) || ctrl.sum;
    end
    if (ctrl.append) begin
      rank_value <= '0;
      status     <= full ? rank9_pkg::ST_FULL : rank9_pkg::ST_OK;
    end else if (ctrl.read && beyond_q) begin
      rank_value <= '0;
      status     <= rank9_pkg::ST_BEYOND;
    end else if (ctrl.sum) begin
      rank_value <= rank9_pkg::RANK_W'(base_q + rank9_pkg::TOTAL_W'(sub_q) +
                                       rank9_pkg::TOTAL_W'(pc_q));
      status     <= rank9_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rank9_bitvector_rank_top.sv
// Top level of the rank9 bit-vector rank block.
// Depends on rank9_pkg, rank9_ctrl and rank9_dp.
//
//   Channel   Handshake            Payload ports
//   command   start, busy          command, data_word, bit_position
//   result    done (1-cycle beat)  rank_value, status
//
// An append captures its beat on accept, then does the popcount and the memory
// writes in its append step. A query does a synchronous read of the word and count
// memories, a masked popcount, then the final add; a query past the loaded words
// returns from its read step. A clear gives no result. Reset clears the counters
// at once; the memories need no clearing pass. The result beat is registered and
// cannot be stalled.
`default_nettype none

module rank9_bitvector_rank_top #(
  parameter int MAX_WORDS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   command,
  input  wire logic [63:0]  data_word,
  input  wire logic [15:0]  bit_position,
  output logic              done,
  output logic [15:0]       rank_value,
  output logic [1:0]        status
);

  rank9_pkg::ctrl_t    ctrl;
  rank9_pkg::dp_stat_t dp_stat;

  rank9_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .dp_stat (dp_stat),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  rank9_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .data_word    (data_word),
    .bit_position (bit_position),
    .dp_stat      (dp_stat),
    .done         (done),
    .rank_value   (rank_value),
    .status       (status)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for rank9_bitvector_rank_top: append, rank query and clear beats.
// Depends on rank9_pkg and the RTL of the rank block; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_WORDS = 1024;
  localparam int BLOCK_COUNT = (STORE_WORDS + 7) / 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One expected result beat.
  typedef struct packed {
    logic [15:0] rank;
    logic [1:0]  status;
  } rank_reply_t;

  // Shadow copy of the rank structure plus the queue of results still owed.
  class rank_scoreboard;
    logic [63:0]   words [STORE_WORDS];
    logic [16:0]   base_cnt [BLOCK_COUNT];
    logic [62:0]   sub_cnt [BLOCK_COUNT];
    int unsigned   loaded;
    logic [16:0]   total;
    logic [9:0]    blk_run;
    rank_reply_t   owed_replies [$];
    int unsigned   errors;

    function new();
      loaded  = 0;
      total   = '0;
      blk_run = '0;
      errors  = 0;
    endfunction

    static function int unsigned ones_in(logic [63:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 64; i++) n += v[i];
      return n;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    // Update the shadow state for an accepted command and queue its result, if it has one.
    function void note_command(logic [1:0] cmd, logic [63:0] word, logic [15:0] pos);
      int unsigned slot;
      int unsigned blk;
      int unsigned k;
      int unsigned pc;
      int unsigned w;
      int unsigned s;
      logic [8:0]  sub;
      logic [63:0] mask;
      logic [16:0] sum;
      rank_reply_t r;
      r = '0;
      case (cmd)
        rank9_pkg::CMD_APPEND: begin
          if (loaded >= STORE_WORDS) begin
            r.status = rank9_pkg::ST_FULL;
          end else begin
            slot = loaded;
            blk = slot >> 3;
            k = slot & 7;
            // The first word of a block latches the base count and restarts the sub-counts.
            if (k == 0) begin
              base_cnt[blk] = total;
              sub_cnt[blk] = '0;
              blk_run = '0;
            end
            words[slot] = word;
            pc = ones_in(word);
            blk_run = blk_run + 10'(pc);
            if (k < 7) sub_cnt[blk][9*k +: 9] = blk_run[8:0];
            total = total + 17'(pc);
            loaded = slot + 1;
            r.status = rank9_pkg::ST_OK;
          end
          owed_replies.insert(owed_replies.size(), r);
        end
        rank9_pkg::CMD_QUERY: begin
          w = pos[15:6];
          if (w >= loaded) begin
            r.status = rank9_pkg::ST_BEYOND;
          end else begin
            s = w & 7;
            sub = (s != 0) ? sub_cnt[w >> 3][9*(s-1) +: 9] : 9'd0;
            mask = (64'd1 << pos[5:0]) - 64'd1;
            sum = base_cnt[w >> 3] + 17'(sub) + 17'(ones_in(words[w] & mask));
            r.rank = sum[15:0];
            r.status = rank9_pkg::ST_OK;
          end
          owed_replies.insert(owed_replies.size(), r);
        end
        rank9_pkg::CMD_CLEAR: begin
          loaded = 0;
          total = '0;
          blk_run = '0;
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(logic [15:0] rank, logic [1:0] st);
      rank_reply_t e;
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual rank %0d status %0d",
                 $time, rank, st);
        errors++;
        return;
      end
      e = owed_replies.pop_front();
      if (rank !== e.rank) begin
        $display("%0t: rank_value mismatch: expected %0d, actual %0d", $time, e.rank, rank);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [63:0] data_word;
  logic [15:0] bit_position;
  logic        done;
  logic [15:0] rank_value;
  logic [1:0]  status;

  rank_scoreboard sb;
  int unsigned    sender_idle_pct;
  int unsigned    items_sent;

  rank9_bitvector_rank_top #(.MAX_WORDS(STORE_WORDS)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .data_word(data_word),
    .bit_position(bit_position),
    .done(done),
    .rank_value(rank_value),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every result beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done && sb != null) sb.check_result(rank_value, status);
  end

  // Hold the sender off until every owed result has come back.
  task automatic wait_for_quiet();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Send one command beat; called and returning at a falling edge.
  task automatic send_item(input logic [1:0] cmd, input logic [63:0] word,
                           input logic [15:0] pos);
    int unsigned pct;
    pct = (items_sent < 300) ? 0 : (items_sent < 600) ? 47 : (items_sent < 900) ? 0 : 32;
    if (pct != sender_idle_pct) begin
      wait_for_quiet();
      sender_idle_pct = pct;
    end
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    data_word = word;
    bit_position = pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, word, pos);
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly dense words so that a full store pushes the rank past 32768.
  function automatic logic [63:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return '1;
    if (r < 8) return {$urandom, $urandom};
    if (r == 8) return '0;
    return 64'd1 << $urandom_range(0, 63);
  endfunction

  // Query positions: mostly inside the loaded words, plus word edges and the end.
  function automatic logic [15:0] pick_position(int unsigned n);
    int unsigned r;
    logic [9:0]  w;
    r = $urandom_range(0, 9);
    if (n == 0 || r == 0) return 16'($urandom);
    w = 10'($urandom_range(0, n - 1));
    if (r == 1 && n < STORE_WORDS) return 16'(n * 64);
    if (r == 2) return {w, 6'd0};
    if (r == 3) return {w, 6'd63};
    return 16'($urandom_range(0, n * 64 - 1));
  endfunction

  task automatic send_append();
    send_item(rank9_pkg::CMD_APPEND, pick_word(), 16'($urandom));
  endtask

  task automatic send_query();
    send_item(rank9_pkg::CMD_QUERY, {$urandom, $urandom}, pick_position(sb.loaded));
  endtask

  initial begin
    int unsigned ops;
    sb = new();
    sender_idle_pct = 0;
    items_sent = 0;
    rst = 1'b1;
    start = 1'b0;
    command = rank9_pkg::CMD_APPEND;
    data_word = '0;
    bit_position = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty store, word edges, the end of the loaded bits, block edges, clear.
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd0);
    send_item(rank9_pkg::CMD_APPEND, '1, '0);
    send_item(rank9_pkg::CMD_APPEND, '0, '0);
    send_item(rank9_pkg::CMD_APPEND, 64'h8000_0000_0000_0001, '0);
    send_item(rank9_pkg::CMD_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd0);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd63);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd64);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd191);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd192);
    send_item(rank9_pkg::CMD_QUERY, '1, 16'd255);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd256);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'hFFFF);
    send_item(CMD_UNUSED, '1, 16'd5);
    send_item(rank9_pkg::CMD_APPEND, {$urandom, $urandom}, '0);
    send_item(rank9_pkg::CMD_APPEND, '1, '0);
    send_item(rank9_pkg::CMD_APPEND, '1, '0);
    send_item(rank9_pkg::CMD_APPEND, 64'h5555_5555_5555_5555, '0);
    send_item(rank9_pkg::CMD_APPEND, 64'hFFFF_0000_FFFF_0000, '0);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd458);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd517);
    send_item(rank9_pkg::CMD_CLEAR, '1, '1);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd0);
    send_item(rank9_pkg::CMD_APPEND, 64'd1, '0);
    send_item(rank9_pkg::CMD_QUERY, '0, 16'd1);

    // Short episodes: clear, then appends and queries, with stray and broken commands.
    while (items_sent < 100) begin
      send_item(rank9_pkg::CMD_CLEAR, {$urandom, $urandom}, 16'($urandom));
      ops = $urandom_range(10, 40);
      repeat (ops) begin
        case ($urandom_range(0, 19))
          0: send_item(CMD_UNUSED, {$urandom, $urandom}, 16'($urandom));
          1: send_item(rank9_pkg::CMD_CLEAR, {$urandom, $urandom}, 16'($urandom));
          2, 3, 4, 5, 6, 7, 8, 9: send_append();
          default: send_query();
        endcase
      end
    end

    // Fill the whole store with queries mixed in, then push past the end.
    send_item(rank9_pkg::CMD_CLEAR, '0, '0);
    while (sb.loaded < STORE_WORDS) begin
      if ($urandom_range(0, 99) < 7) send_query();
      else send_append();
    end
    repeat (40) begin
      case ($urandom_range(0, 7))
        0, 1: send_append();
        2: send_item(rank9_pkg::CMD_QUERY, '0, 16'($urandom_range(65344, 65535)));
        3: send_item(CMD_UNUSED, {$urandom, $urandom}, 16'($urandom));
        default: send_query();
      endcase
    end
    send_item(rank9_pkg::CMD_QUERY, '0, 16'hFFFF);
    send_item(rank9_pkg::CMD_APPEND, '1, '0);

    // Reuse after a full store: old memory contents must not leak into new ranks.
    send_item(rank9_pkg::CMD_CLEAR, '0, '0);
    repeat (25) begin
      if ($urandom_range(0, 1) == 0) send_append();
      else send_query();
    end

    // Drain the last results and let the block settle.
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
